FILE: hdl/bqt_pkg.sv
// package for the bilinear quad tessellator
// shared constants, types and weight tables; no dependencies
package bqt_pkg;

   localparam int MaxDivisionsDefault = 5;
   localparam int OneQ16 = 65536;

   // corner slot numbers
   localparam logic [1:0] CORNER_TL = 2'd0;
   localparam logic [1:0] CORNER_BR = 2'd3;

   typedef struct packed {
      logic [1:0]         corner_index;
      logic signed [31:0] corner_pos_x;
      logic signed [31:0] corner_pos_y;
      logic [16:0]        corner_tex_u;
      logic [16:0]        corner_tex_v;
      logic [7:0]         corner_alpha;
      logic [2:0]         grid_cols;
      logic [2:0]         grid_rows;
   } req_type;

   typedef struct packed {
      logic [2:0]         vertex_col;
      logic [2:0]         vertex_row;
      logic signed [31:0] vertex_pos_x;
      logic signed [31:0] vertex_pos_y;
      logic [16:0]        vertex_tex_u;
      logic [16:0]        vertex_tex_v;
      logic [31:0]        vertex_color;
      logic               vertex_last;
   } rsp_type;

   // one grid job handed from front to back
   typedef struct packed {
      logic signed [3:0][31:0] pos_x;
      logic signed [3:0][31:0] pos_y;
      logic [3:0][16:0]        tex_u;
      logic [3:0][16:0]        tex_v;
      logic [3:0][7:0]         alpha;
      logic [2:0]              cols;
      logic [2:0]              rows;
   } job_type;

   // floor(i*65536/n), i<=n<=7, as a 17 bit q1.16 weight
   function automatic logic [16:0] weight(input logic [2:0] i, input logic [2:0] n);
      logic [16:0] w;
      w = '0;
      unique case (n)
         3'd2: w = 17'(i) * 17'd32768;
         3'd3: unique case (i)
            3'd1: w = 17'd21845; 3'd2: w = 17'd43690; 3'd3: w = 17'd65536;
            default: w = '0;
         endcase
         3'd4: w = 17'(i) * 17'd16384;
         3'd5: unique case (i)
            3'd1: w = 17'd13107; 3'd2: w = 17'd26214; 3'd3: w = 17'd39321;
            3'd4: w = 17'd52428; 3'd5: w = 17'd65536; default: w = '0;
         endcase
         3'd6: unique case (i)
            3'd1: w = 17'd10922; 3'd2: w = 17'd21845; 3'd3: w = 17'd32768;
            3'd4: w = 17'd43690; 3'd5: w = 17'd54613; 3'd6: w = 17'd65536;
            default: w = '0;
         endcase
         3'd7: unique case (i)
            3'd1: w = 17'd9362;  3'd2: w = 17'd18724; 3'd3: w = 17'd28086;
            3'd4: w = 17'd37449; 3'd5: w = 17'd46811; 3'd6: w = 17'd56173;
            3'd7: w = 17'd65536; default: w = '0;
         endcase
         default: w = (i != 3'd0) ? 17'd65536 : 17'd0;
      endcase
      return w;
   endfunction

endpackage

FILE: hdl/bqt_stream_if.sv
// valid/ready channel interface carrying a payload of type payload_type
// depends on nothing
interface bqt_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/bqt_front.sv
// front end: stores corners and launches a grid job on corner three
// depends on bqt_pkg
module bqt_front #(
   parameter int MAX_DIVISIONS = bqt_pkg::MaxDivisionsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bqt_pkg::req_type req_word,
   output logic             job_valid,
   input  logic             job_ready,
   output bqt_pkg::job_type job_word
);
   localparam logic [2:0] MaxDiv = 3'(MAX_DIVISIONS);

   bqt_pkg::job_type corners_ff, corners_in;
   logic             job_valid_ff, job_valid_in;
   bqt_pkg::job_type job_ff, job_in;
   logic             take;
   logic [1:0]       k;

   function automatic logic [2:0] clamp(input logic [2:0] c);
      logic [2:0] r;
      r = c;
      if (c == 3'd0) r = 3'd1;
      else if (c > MaxDiv) r = MaxDiv;
      return r;
   endfunction

   assign req_ready = !job_valid_ff || job_ready;
   assign take = req_valid && req_ready;
   assign k = req_word.corner_index;

   always_comb begin
      corners_in = corners_ff;
      if (take) begin
         corners_in.pos_x[k] = req_word.corner_pos_x;
         corners_in.pos_y[k] = req_word.corner_pos_y;
         corners_in.tex_u[k] = req_word.corner_tex_u;
         corners_in.tex_v[k] = req_word.corner_tex_v;
         corners_in.alpha[k] = req_word.corner_alpha;
      end
      corners_in.cols = clamp(req_word.grid_cols);
      corners_in.rows = clamp(req_word.grid_rows);
      job_valid_in = job_valid_ff && !job_ready;
      job_in = job_ff;
      if (take && k == bqt_pkg::CORNER_BR) begin
         job_valid_in = 1'b1;
         job_in = corners_in;
      end
   end

   always_ff @(posedge clock) begin
      corners_ff <= corners_in;
      job_ff <= job_in;
      if (reset) job_valid_ff <= 1'b0;
      else job_valid_ff <= job_valid_in;
   end

   assign job_valid = job_valid_ff;
   assign job_word = job_ff;
endmodule

FILE: hdl/bqt_back.sv
// back end: walks the grid and computes one vertex per cycle in a pipeline while rsp does not stall
// depends on bqt_pkg
module bqt_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  bqt_pkg::job_type job_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bqt_pkg::rsp_type rsp_word
);
   typedef enum logic {IDLE, RUN} state_type;
   state_type        state_ff;
   bqt_pkg::job_type job_ff;
   logic [2:0]       x_ff, y_ff;

   // pipeline: s1 factors, s2 products, s3 sums/alpha square, s4 output
   logic             v1_ff, v2_ff, v3_ff, v4_ff;
   logic [2:0]       x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff;
   logic             l1_ff, l2_ff, l3_ff;
   logic [3:0][16:0] f1_ff;
   logic signed [3:0][48:0] px2_ff, py2_ff;
   logic [3:0][33:0] tu2_ff, tv2_ff;
   logic [3:0][24:0] a2_ff;
   logic signed [31:0] px3_ff, py3_ff;
   logic [16:0]      tu3_ff, tv3_ff;
   logic [31:0]      asq3_ff;
   bqt_pkg::rsp_type out_ff;

   logic             adv;
   logic             last_pt;
   logic [16:0]      wx, wy, nx, ny;
   logic [3:0][16:0] f_in;
   logic signed [35:0] sx, sy;
   logic [16:0]      su, sv;
   logic [15:0]      ai;
   logic [7:0]       abyte;

   // stall whole pipe when the output register is held
   assign adv = !v4_ff || rsp_ready;
   // a job is only taken on an edge where the pipe moves
   assign job_ready = (state_ff == IDLE) && adv;
   assign last_pt = (x_ff == job_ff.cols) && (y_ff == job_ff.rows);

   always_comb begin
      wx = bqt_pkg::weight(x_ff, job_ff.cols);
      wy = bqt_pkg::weight(y_ff, job_ff.rows);
      nx = 17'(bqt_pkg::OneQ16) - wx;
      ny = 17'(bqt_pkg::OneQ16) - wy;
      f_in[0] = 17'((34'(nx) * 34'(ny)) >> 16);
      f_in[1] = 17'((34'(wx) * 34'(ny)) >> 16);
      f_in[2] = 17'((34'(nx) * 34'(wy)) >> 16);
      f_in[3] = 17'((34'(wx) * 34'(wy)) >> 16);
   end

   // elements of a packed array read back unsigned, so position terms are recast
   always_comb begin
      sx = '0; sy = '0; su = '0; sv = '0; ai = '0;
      for (int i = 0; i < 4; i++) begin
         sx = sx + 36'($signed(px2_ff[i]) >>> 16);
         sy = sy + 36'($signed(py2_ff[i]) >>> 16);
         su = su + 17'(tu2_ff[i] >> 16);
         sv = sv + 17'(tv2_ff[i] >> 16);
         ai = ai + 16'(a2_ff[i] >> 8);
      end
   end

   // asq/(65536*255): take top 16 bits then divide by 255 via reciprocal
   always_comb begin
      logic [15:0] hi;
      logic [31:0] q;
      logic [15:0] r;
      hi = asq3_ff[31:16];
      q = (32'(hi) * 32'd257) >> 16;
      r = hi - 16'(q[15:0] * 16'd255);
      if (r >= 16'd255) q = q + 32'd1;
      abyte = (q > 32'd255) ? 8'd255 : q[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= (state_ff == RUN);
         v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         unique case (state_ff)
            IDLE: if (job_valid) begin
               job_ff <= job_word;
               x_ff <= '0; y_ff <= '0;
               state_ff <= RUN;
            end
            RUN: begin
               if (last_pt) state_ff <= IDLE;
               else if (x_ff == job_ff.cols) begin
                  x_ff <= '0; y_ff <= y_ff + 3'd1;
               end else x_ff <= x_ff + 3'd1;
            end
            default: state_ff <= IDLE;
         endcase
      end
      if (adv) begin
         x1_ff <= x_ff; y1_ff <= y_ff; l1_ff <= last_pt; f1_ff <= f_in;
         x2_ff <= x1_ff; y2_ff <= y1_ff; l2_ff <= l1_ff;
         for (int i = 0; i < 4; i++) begin
            px2_ff[i] <= $signed(job_ff.pos_x[i]) * $signed({1'b0, f1_ff[i]});
            py2_ff[i] <= $signed(job_ff.pos_y[i]) * $signed({1'b0, f1_ff[i]});
            tu2_ff[i] <= 34'(job_ff.tex_u[i]) * 34'(f1_ff[i]);
            tv2_ff[i] <= 34'(job_ff.tex_v[i]) * 34'(f1_ff[i]);
            a2_ff[i] <= 25'(job_ff.alpha[i]) * 25'(f1_ff[i]);
         end
         x3_ff <= x2_ff; y3_ff <= y2_ff; l3_ff <= l2_ff;
         px3_ff <= (sx > 36'sd2147483647) ? 32'sh7fffffff :
                   (sx < -36'sd2147483648) ? 32'sh80000000 : 32'(sx);
         py3_ff <= (sy > 36'sd2147483647) ? 32'sh7fffffff :
                   (sy < -36'sd2147483648) ? 32'sh80000000 : 32'(sy);
         tu3_ff <= su; tv3_ff <= sv;
         asq3_ff <= 32'(ai) * 32'(ai);
         out_ff.vertex_col <= x3_ff;
         out_ff.vertex_row <= y3_ff;
         out_ff.vertex_pos_x <= px3_ff;
         out_ff.vertex_pos_y <= py3_ff;
         out_ff.vertex_tex_u <= tu3_ff;
         out_ff.vertex_tex_v <= tv3_ff;
         out_ff.vertex_color <= {abyte, 24'hffffff};
         out_ff.vertex_last <= l3_ff;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_word = out_ff;
endmodule

FILE: hdl/bilinear_quad_tessellator.sv
// top level of the bilinear quad tessellator
// depends on bqt_pkg, bqt_stream_if, bqt_front and bqt_back
//
// usage: send four corner words on req (corner_index 0..3), each with
// position, texture coordinate and alpha; the word for corner three also
// carries grid_cols and grid_rows and launches a grid of
// (cols+1)*(rows+1) vertices on rsp in row-major order, last one flagged.
// corners 0..2 are absorbed and make no output.
// the front end holds one launched job in a one-deep queue, so the next
// quad's corners are taken while the back end still walks the grid.
// the back end issues one vertex per cycle while rsp does not stall, through a
// four-stage pipe (weights, products, sums, output register); corner three
// passes the front job register and the back job register before the pipe;
// a job is loaded in the idle state and its grid walked before the next one.
// a stalled rsp freezes the whole back pipe and, once the queue is full,
// every corner word waits on req; no vertex is lost.
// reset clears control only; corner storage is undefined until written.
module bilinear_quad_tessellator #(
   parameter int MAX_DIVISIONS = bqt_pkg::MaxDivisionsDefault
) (
   input logic clock,
   input logic reset,
   bqt_stream_if.sink   req,
   bqt_stream_if.source rsp
);
   // queue between front and back
   logic             job_valid;
   logic             job_ready;
   bqt_pkg::job_type job_word;

   bqt_front #(.MAX_DIVISIONS(MAX_DIVISIONS)) u_front (
      .clock, .reset,
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_word  (req.payload),
      .job_valid, .job_ready, .job_word
   );

   bqt_back u_back (
      .clock, .reset,
      .job_valid, .job_ready, .job_word,
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_word  (rsp.payload)
   );

   // a held output word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("rsp word changed while stalled");

   // a launched job is never dropped by the queue
   a_job_hold: assert property (@(posedge clock) disable iff (reset)
      job_valid && !job_ready |=> job_valid)
      else $error("queued job lost");

   // indices never exceed the clamp
   a_idx: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.payload.vertex_col <= 3'(MAX_DIVISIONS)
                 && rsp.payload.vertex_row <= 3'(MAX_DIVISIONS))
      else $error("vertex index out of range");
endmodule

FILE: test/bqt_checker.sv
// vertex checker for the bilinear quad tessellator testbench
// watches req and rsp, predicts each grid vertex and compares; depends on bqt_pkg
module bqt_checker #(
   parameter int MAX_DIVISIONS = bqt_pkg::MaxDivisionsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  bqt_pkg::req_type req_payload,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  bqt_pkg::rsp_type rsp_payload,
   output int   errors,
   output int   vertices_pending
);
   logic signed [31:0] quad_pos_x [4];
   logic signed [31:0] quad_pos_y [4];
   logic [16:0]        quad_tex_u [4];
   logic [16:0]        quad_tex_v [4];
   logic [7:0]         quad_alpha [4];
   bqt_pkg::rsp_type   vertex_queue [$];

   assign vertices_pending = vertex_queue.size();

   function automatic int clamp_divisions(input logic [2:0] c);
      if (c == 0) return 1;
      if (c > MAX_DIVISIONS) return MAX_DIVISIONS;
      return c;
   endfunction

   // sum of floor(c*f/65536), saturated to 32 bits signed
   function automatic logic signed [31:0] blend_signed(input logic signed [31:0] c [4],
                                                      input longint f [4]);
      longint s, p;
      s = 0;
      for (int i = 0; i < 4; i++) begin
         p = longint'(c[i]) * f[i];
         s += p >>> 16;
      end
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s[31:0];
   endfunction

   function automatic logic [16:0] blend_unsigned(input logic [16:0] c [4], input longint f [4]);
      longint s;
      s = 0;
      for (int i = 0; i < 4; i++) s += (longint'(c[i]) * f[i]) >> 16;
      return s[16:0];
   endfunction

   task automatic predict_grid(input int cols, input int rows);
      longint wx, wy, ai, abyte;
      longint f [4];
      bqt_pkg::rsp_type v;
      for (int y = 0; y <= rows; y++) begin
         wy = (longint'(y) * 65536) / rows;
         for (int x = 0; x <= cols; x++) begin
            wx = (longint'(x) * 65536) / cols;
            f[0] = ((65536 - wx) * (65536 - wy)) >> 16;
            f[1] = (wx * (65536 - wy)) >> 16;
            f[2] = ((65536 - wx) * wy) >> 16;
            f[3] = (wx * wy) >> 16;
            ai = 0;
            for (int i = 0; i < 4; i++) ai += (longint'(quad_alpha[i]) * f[i]) >> 8;
            abyte = (ai * ai) / (64'd65536 * 255);
            if (abyte > 255) abyte = 255;
            v.vertex_col   = 3'(x);
            v.vertex_row   = 3'(y);
            v.vertex_pos_x = blend_signed(quad_pos_x, f);
            v.vertex_pos_y = blend_signed(quad_pos_y, f);
            v.vertex_tex_u = blend_unsigned(quad_tex_u, f);
            v.vertex_tex_v = blend_unsigned(quad_tex_v, f);
            v.vertex_color = {abyte[7:0], 24'hFFFFFF};
            v.vertex_last  = (x == cols && y == rows);
            vertex_queue.push_back(v);
         end
      end
   endtask

   task automatic compare_field(input string name, input longint e, input longint a);
      if (e != a) begin
         $error("%s: expected %0h, actual %0h", name, e, a);
         errors++;
      end
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      bqt_pkg::rsp_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (vertex_queue.size() == 0) begin
               $error("unexpected vertex col %0d row %0d",
                      rsp_payload.vertex_col, rsp_payload.vertex_row);
               errors++;
            end else begin
               e = vertex_queue.pop_front();
               compare_field("vertex_col", e.vertex_col, rsp_payload.vertex_col);
               compare_field("vertex_row", e.vertex_row, rsp_payload.vertex_row);
               compare_field("vertex_pos_x", e.vertex_pos_x, rsp_payload.vertex_pos_x);
               compare_field("vertex_pos_y", e.vertex_pos_y, rsp_payload.vertex_pos_y);
               compare_field("vertex_tex_u", e.vertex_tex_u, rsp_payload.vertex_tex_u);
               compare_field("vertex_tex_v", e.vertex_tex_v, rsp_payload.vertex_tex_v);
               compare_field("vertex_color", e.vertex_color, rsp_payload.vertex_color);
               compare_field("vertex_last", e.vertex_last, rsp_payload.vertex_last);
            end
         end
         if (req_valid && req_ready) begin
            quad_pos_x[req_payload.corner_index] = req_payload.corner_pos_x;
            quad_pos_y[req_payload.corner_index] = req_payload.corner_pos_y;
            quad_tex_u[req_payload.corner_index] = req_payload.corner_tex_u;
            quad_tex_v[req_payload.corner_index] = req_payload.corner_tex_v;
            quad_alpha[req_payload.corner_index] = req_payload.corner_alpha;
            if (req_payload.corner_index == bqt_pkg::CORNER_BR)
               predict_grid(clamp_divisions(req_payload.grid_cols),
                            clamp_divisions(req_payload.grid_rows));
         end
      end
   end
endmodule

FILE: test/tb.sv
// top of the bilinear quad tessellator testbench
// drives corner words, stalls the vertex side and gives the verdict; uses bqt_checker
module tb;
   localparam int IdleLimit = 2000;

   logic clock = 0;
   logic reset = 1;
   int   errors;
   int   vertices_pending;
   int   idle_cycles = 0;
   bit   calm = 0;        // stretch with no idling on either side

   bqt_stream_if #(.payload_type(bqt_pkg::req_type)) req ();
   bqt_stream_if #(.payload_type(bqt_pkg::rsp_type)) rsp ();

   bilinear_quad_tessellator dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   bqt_checker check (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_payload(req.payload),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload),
      .errors(errors), .vertices_pending(vertices_pending)
   );

   always #5 clock = ~clock;

   // sink side: ready drops about 16 percent of the time outside the calm stretch
   always @(posedge clock) begin
      if (reset) rsp.ready <= 0;
      else rsp.ready <= calm || ($urandom_range(99) >= 16);
   end

   // watchdog on cycles with no accepted word on either side
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic logic signed [31:0] pick_coord(input int sel);
      case (sel)
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [16:0] pick_tex();
      case ($urandom_range(3))
         0: return 17'd65536;
         1: return 17'd0;
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   // send one corner word, with idle gaps at random
   task automatic send_corner(input logic [1:0] idx, input logic signed [31:0] px,
                              input logic signed [31:0] py, input logic [16:0] u,
                              input logic [16:0] v, input logic [7:0] a,
                              input logic [2:0] cols, input logic [2:0] rows);
      bqt_pkg::req_type w;
      while (!calm && $urandom_range(99) < 16) begin
         req.valid <= 0;
         @(posedge clock);
      end
      w.corner_index = idx;
      w.corner_pos_x = px;
      w.corner_pos_y = py;
      w.corner_tex_u = u;
      w.corner_tex_v = v;
      w.corner_alpha = a;
      w.grid_cols = cols;
      w.grid_rows = rows;
      req.valid <= 1;
      req.payload <= w;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // whole quad in corner order, ending with corner three and the grid size
   task automatic send_quad(input int sel, input logic [2:0] cols, input logic [2:0] rows);
      for (int c = 0; c < 4; c++)
         send_corner(2'(c), pick_coord(sel == 3 ? $urandom_range(3) : sel),
                     pick_coord(sel == 3 ? $urandom_range(3) : sel), pick_tex(), pick_tex(),
                     sel == 0 ? 8'hFF : (sel == 2 ? 8'h00 : 8'($urandom)), cols, rows);
   endtask

   initial begin
      int sent;
      req.valid = 0;
      req.payload = '0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // extremes: all max, all min, zero and oversize grid counts
      send_quad(0, 3'd7, 3'd7);
      send_quad(1, 3'd0, 3'd0);
      send_quad(2, 3'd1, 3'd5);
      send_quad(3, 3'd6, 3'd2);
      // repeated corner: slot two is overwritten before corner three
      send_corner(bqt_pkg::CORNER_TL, 32'sd0, 32'sd0, 17'd65536, 17'd0, 8'hFF, 3'd2, 3'd2);
      send_corner(2'd1, -32'sd65536, 32'sd65536, 17'd0, 17'd65536, 8'h80, 3'd2, 3'd2);
      send_corner(2'd2, 32'sd1, 32'sd1, 17'd1, 17'd1, 8'h01, 3'd2, 3'd2);
      send_corner(2'd2, 32'sd12345, -32'sd777, 17'd4000, 17'd60000, 8'h7F, 3'd2, 3'd2);
      send_corner(bqt_pkg::CORNER_BR, 32'sh7FFF0000, 32'sh80010000, 17'd32768, 17'd32768,
                  8'hC0, 3'd4, 3'd3);
      sent = 21;

      // random quads; a calm stretch in the middle, and some stray repeated corners
      while (sent < 180) begin
         calm = (sent > 80 && sent < 120);
         if ($urandom_range(9) == 0) begin
            send_corner(2'($urandom_range(2)), $urandom, $urandom, pick_tex(), pick_tex(),
                        8'($urandom), 3'($urandom), 3'($urandom));
            sent++;
         end
         // small grids mostly, sometimes any size up to the largest
         if ($urandom_range(4) == 0) send_quad(3, 3'($urandom), 3'($urandom));
         else send_quad(3, 3'($urandom_range(3)), 3'($urandom_range(3)));
         sent += 4;
      end
      calm = 0;
      req.valid <= 0;

      while (vertices_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
